FILE: rtl/frdd_pkg.sv
// frdd_pkg: shared constants, the arctangent step table and the side-band
// struct of the field-relative drive direction pipeline. No dependencies.
package frdd_pkg;

   localparam int CORDIC_STEPS_DEF = 16;
   localparam int AXIS_BITS_DEF    = 12;

   // angle formats: CORDIC angle in 2^-20 degree, results in 1/16 degree
   localparam int ANG_FRAC     = 20;
   localparam int ROUND_SHIFT  = ANG_FRAC - 4;
   localparam int ZW           = 31;
   localparam int ANG_W        = 13;
   localparam int FULL_TURN    = 5760;
   localparam int HALF_TURN    = 2880;
   localparam int QUARTER_TURN = 1440;
   localparam int THREE_QUARTER_TURN = 4320;

   // stick axes are scaled up by this shift before rotating
   localparam int PRE_SHIFT = 24;

   localparam int TABLE_LEN = 24;
   localparam int ATAN_W    = 26;

   // heading reduction: 5760 = 45 * 2^7, 45 handled by a reciprocal multiply
   localparam int HEAD_W      = 32;
   localparam int HEAD_LO_BITS = 7;
   localparam int HEAD_DIV    = 45;
   localparam int HEAD_REM_W  = 6;
   localparam int HV_W        = HEAD_W - HEAD_LO_BITS;
   localparam int HEAD_SHIFT  = 31;
   localparam int HR_W        = 26;
   localparam logic [HR_W-1:0] HEAD_RECIP =
      HR_W'(((64'd1 << HEAD_SHIFT) + 64'(HEAD_DIV) - 64'd1) / 64'(HEAD_DIV));
   localparam int HP_W        = HV_W + HR_W;
   localparam int HQ_W        = HP_W - HEAD_SHIFT;
   // offset added by flipping the heading's sign bit, taken modulo a turn
   localparam int HEAD_BIAS   = int'((64'd1 << (HEAD_W - 1)) % 64'(FULL_TURN));

   typedef struct packed {
      logic             fixed;      // stick centered or on an axis
      logic [ANG_W-1:0] fixed_ang;  // angle for those cases
      logic [ANG_W-1:0] robot;      // heading reduced into one turn
   } side_type;

   // atan(2^-i) in 2^-20 degree
   function automatic logic [ATAN_W-1:0] atan_step(input int idx);
      logic [ATAN_W-1:0] v;
      case (idx)
         0:  v = 26'd47185920;
         1:  v = 26'd27855475;
         2:  v = 26'd14718068;
         3:  v = 26'd7471121;
         4:  v = 26'd3750058;
         5:  v = 26'd1876857;
         6:  v = 26'd938658;
         7:  v = 26'd469357;
         8:  v = 26'd234682;
         9:  v = 26'd117342;
         10: v = 26'd58671;
         11: v = 26'd29335;
         12: v = 26'd14668;
         13: v = 26'd7334;
         14: v = 26'd3667;
         15: v = 26'd1833;
         16: v = 26'd917;
         17: v = 26'd458;
         18: v = 26'd229;
         19: v = 26'd115;
         20: v = 26'd57;
         21: v = 26'd29;
         22: v = 26'd14;
         23: v = 26'd7;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

FILE: rtl/frdd_if.sv
// frdd_req_if / frdd_rsp_if: valid/ready channels of the drive direction unit.
// Depends on frdd_pkg.
interface frdd_req_if #(parameter int AXIS_BITS = frdd_pkg::AXIS_BITS_DEF);
   logic                                  valid;
   logic                                  ready;
   logic signed [AXIS_BITS-1:0]           stick_x;
   logic signed [AXIS_BITS-1:0]           stick_y_raw;
   logic signed [frdd_pkg::HEAD_W-1:0]    heading;

   modport source (output valid, stick_x, stick_y_raw, heading, input ready);
   modport sink   (input valid, stick_x, stick_y_raw, heading, output ready);
endinterface

interface frdd_rsp_if #(parameter int AXIS_BITS = frdd_pkg::AXIS_BITS_DEF);
   logic                                  valid;
   logic                                  ready;
   logic signed [frdd_pkg::ANG_W-1:0]     direction_change;
   logic        [AXIS_BITS-1:0]           speed;

   modport source (output valid, direction_change, speed, input ready);
   modport sink   (input valid, direction_change, speed, output ready);
endinterface

FILE: rtl/frdd_prep.sv
// frdd_prep: two front stages - axis squares, heading reduction, CORDIC seed.
// Depends on frdd_pkg.
module frdd_prep #(
   parameter int AXIS_BITS = frdd_pkg::AXIS_BITS_DEF
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           up_valid,
   output logic                                           up_ready,
   input  logic signed [AXIS_BITS-1:0]                    stick_x,
   input  logic signed [AXIS_BITS-1:0]                    stick_y_raw,
   input  logic signed [frdd_pkg::HEAD_W-1:0]             heading,
   output logic                                           dn_valid,
   input  logic                                           dn_ready,
   output logic signed [AXIS_BITS+frdd_pkg::PRE_SHIFT+1:0] a_dn,
   output logic signed [AXIS_BITS+frdd_pkg::PRE_SHIFT+1:0] b_dn,
   output logic signed [frdd_pkg::ZW-1:0]                 z_dn,
   output logic        [2*AXIS_BITS-1:0]                  sq_dn,
   output frdd_pkg::side_type                             side_dn
);
   import frdd_pkg::*;

   localparam int CW = AXIS_BITS + PRE_SHIFT + 2;
   localparam int SW = 2 * AXIS_BITS;
   localparam int YW = AXIS_BITS + 1;
   localparam logic signed [ZW-1:0] HalfZ = ZW'(180 * (1 << ANG_FRAC));

   logic v1_ff, v2_ff, r1, r2;

   // stage 1 registers
   logic signed [AXIS_BITS-1:0] x_ff;
   logic signed [YW-1:0]        y_ff, y_in;
   logic        [SW-1:0]        xx_ff, xx_in, yy_ff, yy_in;
   logic signed [2*YW-1:0]      yy_full;
   logic        [HV_W-1:0]      hv_ff, hv_in;
   logic        [HEAD_LO_BITS-1:0] hl_ff;
   logic        [HP_W-1:0]      hp_ff, hp_in;

   // stage 2
   logic signed [CW-1:0] a_ff, a_in, b_ff, b_in, xw, yw;
   logic signed [ZW-1:0] z_ff, z_in;
   logic        [SW-1:0] sq_ff;
   side_type             side_ff, side_in;
   logic [HQ_W-1:0]      hq;
   logic [HV_W-1:0]      hr_full, hr;
   logic [ANG_W-1:0]     robot_u, robot;

   assign r2       = !v2_ff || dn_ready;
   assign r1       = !v1_ff || r2;
   assign up_ready = r1;

   always_comb begin
      y_in    = YW'(0) - {stick_y_raw[AXIS_BITS-1], stick_y_raw};
      xx_in   = stick_x * stick_x;
      yy_full = y_in * y_in;
      yy_in   = yy_full[SW-1:0];
      // flipping the sign bit adds 2^31, making the heading unsigned
      hv_in   = {~heading[HEAD_W-1], heading[HEAD_W-2:HEAD_LO_BITS]};
      hp_in   = hv_in * HEAD_RECIP;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (r1) begin
         v1_ff <= up_valid;
      end
      if (r1 && up_valid) begin
         x_ff  <= stick_x;
         y_ff  <= y_in;
         xx_ff <= xx_in;
         yy_ff <= yy_in;
         hv_ff <= hv_in;
         hl_ff <= heading[HEAD_LO_BITS-1:0];
         hp_ff <= hp_in;
      end
   end

   always_comb begin
      // remainder of the upper heading bits by 45
      hq      = hp_ff[HP_W-1:HEAD_SHIFT];
      hr_full = hv_ff - HV_W'(hq * HEAD_DIV);
      hr      = (hr_full >= HV_W'(HEAD_DIV)) ? HV_W'(hr_full - HV_W'(HEAD_DIV)) : hr_full;
      robot_u = {hr[HEAD_REM_W-1:0], hl_ff};
      // take back the 2^31 offset, modulo one turn
      if (robot_u >= ANG_W'(HEAD_BIAS)) begin
         robot = ANG_W'(robot_u - ANG_W'(HEAD_BIAS));
      end else begin
         robot = ANG_W'(robot_u + ANG_W'(FULL_TURN - HEAD_BIAS));
      end

      side_in.robot     = robot;
      side_in.fixed     = (x_ff == '0) || (y_ff == '0);
      side_in.fixed_ang = '0;
      if (x_ff == '0) begin
         side_in.fixed_ang = (y_ff > 0 || y_ff == '0) ? '0 : ANG_W'(HALF_TURN);
      end else if (y_ff == '0) begin
         side_in.fixed_ang = (x_ff > 0) ? ANG_W'(QUARTER_TURN) : ANG_W'(THREE_QUARTER_TURN);
      end

      xw = CW'(x_ff);
      yw = CW'(y_ff);
      if (y_ff[YW-1]) begin
         a_in = (-yw) <<< PRE_SHIFT;
         b_in = (-xw) <<< PRE_SHIFT;
         z_in = HalfZ;
      end else begin
         a_in = yw <<< PRE_SHIFT;
         b_in = xw <<< PRE_SHIFT;
         z_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (r2) begin
         v2_ff <= v1_ff;
      end
      if (r2 && v1_ff) begin
         a_ff    <= a_in;
         b_ff    <= b_in;
         z_ff    <= z_in;
         sq_ff   <= xx_ff + yy_ff;
         side_ff <= side_in;
      end
   end

   assign dn_valid = v2_ff;
   assign a_dn     = a_ff;
   assign b_dn     = b_ff;
   assign z_dn     = z_ff;
   assign sq_dn    = sq_ff;
   assign side_dn  = side_ff;

endmodule

FILE: rtl/frdd_cell.sv
// frdd_cell: one link of the chain - at most one CORDIC vectoring step and one root
// digit of the magnitude, registered. Depends on frdd_pkg.
module frdd_cell #(
   parameter int AXIS_BITS    = frdd_pkg::AXIS_BITS_DEF,
   parameter int CORDIC_STEPS = frdd_pkg::CORDIC_STEPS_DEF,
   parameter int IDX          = 0
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           up_valid,
   output logic                                           up_ready,
   input  logic signed [AXIS_BITS+frdd_pkg::PRE_SHIFT+1:0] a_up,
   input  logic signed [AXIS_BITS+frdd_pkg::PRE_SHIFT+1:0] b_up,
   input  logic signed [frdd_pkg::ZW-1:0]                 z_up,
   input  logic        [2*AXIS_BITS-1:0]                  sq_up,
   input  logic        [AXIS_BITS+1:0]                    rem_up,
   input  logic        [AXIS_BITS-1:0]                    root_up,
   input  frdd_pkg::side_type                             side_up,
   output logic                                           dn_valid,
   input  logic                                           dn_ready,
   output logic signed [AXIS_BITS+frdd_pkg::PRE_SHIFT+1:0] a_dn,
   output logic signed [AXIS_BITS+frdd_pkg::PRE_SHIFT+1:0] b_dn,
   output logic signed [frdd_pkg::ZW-1:0]                 z_dn,
   output logic        [2*AXIS_BITS-1:0]                  sq_dn,
   output logic        [AXIS_BITS+1:0]                    rem_dn,
   output logic        [AXIS_BITS-1:0]                    root_dn,
   output frdd_pkg::side_type                             side_dn
);
   import frdd_pkg::*;

   localparam int CW = AXIS_BITS + PRE_SHIFT + 2;
   localparam int SW = 2 * AXIS_BITS;
   localparam int RW = AXIS_BITS + 2;
   localparam int TW = RW + 2;
   localparam bit DoRot  = (IDX < CORDIC_STEPS) && (IDX < TABLE_LEN);
   localparam bit DoRoot = (IDX < AXIS_BITS);
   localparam logic signed [ZW-1:0] StepAng = ZW'(atan_step(IDX));

   logic                 valid_ff;
   logic signed [CW-1:0] a_ff, a_in, b_ff, b_in;
   logic signed [ZW-1:0] z_ff, z_in;
   logic [SW-1:0]        sq_ff, sq_in;
   logic [RW-1:0]        rem_ff, rem_in;
   logic [AXIS_BITS-1:0] root_ff, root_in;
   side_type             side_ff;
   logic [TW-1:0]        rs, trial;

   assign up_ready = !valid_ff || dn_ready;

   always_comb begin
      a_in = a_up;
      b_in = b_up;
      z_in = z_up;
      if (DoRot) begin
         // rotate toward b = 0
         if (!b_up[CW-1]) begin
            a_in = a_up + (b_up >>> IDX);
            b_in = b_up - (a_up >>> IDX);
            z_in = z_up + StepAng;
         end else begin
            a_in = a_up - (b_up >>> IDX);
            b_in = b_up + (a_up >>> IDX);
            z_in = z_up - StepAng;
         end
      end

      rs      = {rem_up, sq_up[SW-1 -: 2]};
      trial   = TW'({root_up, 2'b01});
      sq_in   = sq_up;
      rem_in  = rem_up;
      root_in = root_up;
      if (DoRoot) begin
         sq_in = sq_up << 2;
         if (rs >= trial) begin
            rem_in  = RW'(rs - trial);
            root_in = {root_up[AXIS_BITS-2:0], 1'b1};
         end else begin
            rem_in  = RW'(rs);
            root_in = {root_up[AXIS_BITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
      if (up_ready && up_valid) begin
         a_ff    <= a_in;
         b_ff    <= b_in;
         z_ff    <= z_in;
         sq_ff   <= sq_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
         side_ff <= side_up;
      end
   end

   assign dn_valid = valid_ff;
   assign a_dn     = a_ff;
   assign b_dn     = b_ff;
   assign z_dn     = z_ff;
   assign sq_dn    = sq_ff;
   assign rem_dn   = rem_ff;
   assign root_dn  = root_ff;
   assign side_dn  = side_ff;

endmodule

FILE: rtl/frdd_finish.sv
// frdd_finish: angle rounding and magnitude rounding, then the output
// register with the heading difference wrapped to half a turn. Depends on frdd_pkg.
module frdd_finish #(
   parameter int AXIS_BITS = frdd_pkg::AXIS_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                up_valid,
   output logic                                up_ready,
   input  logic signed [frdd_pkg::ZW-1:0]      z_up,
   input  logic        [AXIS_BITS+1:0]         rem_up,
   input  logic        [AXIS_BITS-1:0]         root_up,
   input  frdd_pkg::side_type                  side_up,
   output logic                                dn_valid,
   input  logic                                dn_ready,
   output logic signed [frdd_pkg::ANG_W-1:0]   direction_change,
   output logic        [AXIS_BITS-1:0]         speed
);
   import frdd_pkg::*;

   localparam logic signed [ZW-1:0] FullZ  = ZW'(360 * (1 << ANG_FRAC));
   localparam logic signed [ZW-1:0] RoundZ = ZW'(1 << (ROUND_SHIFT - 1));

   logic v1_ff, v2_ff, r1, r2;
   logic signed [ZW-1:0]   comp, qz;
   logic [ANG_W-1:0]       q, ang_in, ang_ff, robot_ff;
   logic [AXIS_BITS:0]     sp_full;
   logic [AXIS_BITS-1:0]   sp_in, sp_ff, speed_ff;
   logic signed [ANG_W:0]  d;
   logic signed [ANG_W-1:0] dir_in, dir_ff;

   assign r2       = !v2_ff || dn_ready;
   assign r1       = !v1_ff || r2;
   assign up_ready = r1;

   always_comb begin
      comp = z_up[ZW-1] ? (z_up + FullZ) : z_up;
      qz   = (comp + RoundZ) >>> ROUND_SHIFT;
      q    = ANG_W'(qz);
      if (q >= ANG_W'(FULL_TURN)) begin
         q = '0;
      end
      ang_in = side_up.fixed ? side_up.fixed_ang : q;

      // round to nearest: up when the remainder exceeds the root
      sp_full = {1'b0, root_up} + (AXIS_BITS+1)'(rem_up > {2'b00, root_up});
      sp_in   = sp_full[AXIS_BITS] ? '1 : sp_full[AXIS_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (r1) begin
         v1_ff <= up_valid;
      end
      if (r1 && up_valid) begin
         ang_ff   <= ang_in;
         robot_ff <= side_up.robot;
         sp_ff    <= sp_in;
      end
   end

   always_comb begin
      d = $signed({1'b0, robot_ff}) - $signed({1'b0, ang_ff});
      if (d > HALF_TURN) begin
         d = (ANG_W+1)'(d - FULL_TURN);
      end else if (d < -HALF_TURN) begin
         d = (ANG_W+1)'(d + FULL_TURN);
      end
      dir_in = ANG_W'(d);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (r2) begin
         v2_ff <= v1_ff;
      end
      if (r2 && v1_ff) begin
         dir_ff   <= dir_in;
         speed_ff <= sp_ff;
      end
   end

   assign dn_valid         = v2_ff;
   assign direction_change = dir_ff;
   assign speed            = speed_ff;

endmodule

FILE: rtl/field_relative_drive_direction_unit.sv
// field_relative_drive_direction_unit: top level of the drive direction block.
// Depends on frdd_pkg, frdd_if, frdd_prep, frdd_cell, frdd_finish.
//
// Usage notes
//  - req_chan transfers one joystick sample (stick_x, stick_y_raw, Q1.11) and
//    the gyro heading in 1/16 degree. rsp_chan transfers one result per sample:
//    direction_change (heading minus stick compass angle, wrapped to +/-2880)
//    and speed (stick magnitude, rounded, saturated).
//  - Path: rsp valid rises once the req transfer has passed the 2 front
//    stages, the cell chain, 1 rounding stage and the output register.
//  - Throughput: one transfer per cycle while rsp ready is high. Every stage holds
//    one item and the chain of cells is a pipeline, so a new sample enters each cycle.
//  - The cell count is set by the longer of the CORDIC rotation count and
//    the number of magnitude root digits; each cell does at most one of each.
//  - Stall: when rsp ready is low, items pile up in the stages ahead of the
//    output register; req ready drops only once every stage is full.
//  - Reset (synchronous, active high) clears all stage valid bits; no other
//    state needs clearing, so the block is usable the next cycle.
module field_relative_drive_direction_unit #(
   parameter int CORDIC_STEPS = frdd_pkg::CORDIC_STEPS_DEF,
   parameter int AXIS_BITS    = frdd_pkg::AXIS_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   frdd_req_if.sink   req_chan,
   frdd_rsp_if.source rsp_chan
);
   import frdd_pkg::*;

   localparam int CW    = AXIS_BITS + PRE_SHIFT + 2;
   localparam int SW    = 2 * AXIS_BITS;
   localparam int RW    = AXIS_BITS + 2;
   localparam int Cells = (CORDIC_STEPS > AXIS_BITS) ? CORDIC_STEPS : AXIS_BITS;

   // chain links: index k feeds cell k, index Cells feeds the finish stage
   logic                 lk_valid [Cells+1];
   logic                 lk_ready [Cells+1];
   logic signed [CW-1:0] lk_a     [Cells+1];
   logic signed [CW-1:0] lk_b     [Cells+1];
   logic signed [ZW-1:0] lk_z     [Cells+1];
   logic [SW-1:0]        lk_sq    [Cells+1];
   logic [RW-1:0]        lk_rem   [Cells+1];
   logic [AXIS_BITS-1:0] lk_root  [Cells+1];
   side_type             lk_side  [Cells+1];

   // front: squares, heading reduction, quadrant fold of the stick vector
   frdd_prep #(
      .AXIS_BITS (AXIS_BITS)
   ) u_prep (
      .clock       (clock),
      .reset       (reset),
      .up_valid    (req_chan.valid),
      .up_ready    (req_chan.ready),
      .stick_x     (req_chan.stick_x),
      .stick_y_raw (req_chan.stick_y_raw),
      .heading     (req_chan.heading),
      .dn_valid    (lk_valid[0]),
      .dn_ready    (lk_ready[0]),
      .a_dn        (lk_a[0]),
      .b_dn        (lk_b[0]),
      .z_dn        (lk_z[0]),
      .sq_dn       (lk_sq[0]),
      .side_dn     (lk_side[0])
   );

   // root digit recurrence starts from zero
   assign lk_rem[0]  = '0;
   assign lk_root[0] = '0;

   for (genvar k = 0; k < Cells; k++) begin : g_cell
      frdd_cell #(
         .AXIS_BITS    (AXIS_BITS),
         .CORDIC_STEPS (CORDIC_STEPS),
         .IDX          (k)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (lk_valid[k]),
         .up_ready (lk_ready[k]),
         .a_up     (lk_a[k]),
         .b_up     (lk_b[k]),
         .z_up     (lk_z[k]),
         .sq_up    (lk_sq[k]),
         .rem_up   (lk_rem[k]),
         .root_up  (lk_root[k]),
         .side_up  (lk_side[k]),
         .dn_valid (lk_valid[k+1]),
         .dn_ready (lk_ready[k+1]),
         .a_dn     (lk_a[k+1]),
         .b_dn     (lk_b[k+1]),
         .z_dn     (lk_z[k+1]),
         .sq_dn    (lk_sq[k+1]),
         .rem_dn   (lk_rem[k+1]),
         .root_dn  (lk_root[k+1]),
         .side_dn  (lk_side[k+1])
      );
   end

   // back end: round angle and magnitude, wrap, output register
   frdd_finish #(
      .AXIS_BITS (AXIS_BITS)
   ) u_finish (
      .clock            (clock),
      .reset            (reset),
      .up_valid         (lk_valid[Cells]),
      .up_ready         (lk_ready[Cells]),
      .z_up             (lk_z[Cells]),
      .rem_up           (lk_rem[Cells]),
      .root_up          (lk_root[Cells]),
      .side_up          (lk_side[Cells]),
      .dn_valid         (rsp_chan.valid),
      .dn_ready         (rsp_chan.ready),
      .direction_change (rsp_chan.direction_change),
      .speed            (rsp_chan.speed)
   );

endmodule
